// File: rtl/pal_pkg.sv
`timescale 1ns / 1ps

package pal_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam int OP_W    = 3;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 32;
    localparam int COUNT_W = 6;

    // position compare width: holds count + 1 and any 6-bit position
    localparam int PW = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam int IN_BITS  = OP_W + POS_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 1 + 1 + VAL_W + COUNT_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OP_W-1:0] OP_READ   = 3'd2;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
    localparam logic [OP_W-1:0] OP_APPEND = 3'd4;

    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic signed [VAL_W-1:0] read_value;
        logic                    found;
        logic                    status;
    } result_t;

endpackage

// File: rtl/pal_ram.sv
`timescale 1ns / 1ps

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/pal_outbuf.sv
`timescale 1ns / 1ps

module pal_outbuf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    output logic             res_ready,
    input  pal_pkg::result_t res_data,
    output logic             out_valid,
    input  logic             out_ready,
    output pal_pkg::result_t out_data
);

    logic             full_reg;
    logic             full_next;
    pal_pkg::result_t data_reg;

    assign res_ready = !full_reg || out_ready;

    always_comb
    begin
        full_next = full_reg;
        if (res_valid && res_ready)
        begin
            full_next = 1'b1;
        end
        else if (out_ready)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            data_reg <= res_data;
        end
    end

    assign out_valid = full_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/pal_ctrl.sv
`timescale 1ns / 1ps

module pal_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pal_pkg::OP_W-1:0]    in_op,
    input  logic [pal_pkg::POS_W-1:0]   in_pos,
    input  logic [pal_pkg::VAL_W-1:0]   in_val,
    output logic                        res_valid,
    input  logic                        res_ready,
    output pal_pkg::result_t            res_data,
    output logic                        ram_we,
    output logic [pal_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [pal_pkg::VAL_W-1:0]   ram_wdata,
    output logic [pal_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [pal_pkg::VAL_W-1:0]   ram_rdata
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_RD_WAIT  = 8'b0000_0010,
        ST_SCAN_RD  = 8'b0000_0100,
        ST_SCAN_CMP = 8'b0000_1000,
        ST_SH_RD    = 8'b0001_0000,
        ST_SH_WR    = 8'b0010_0000,
        ST_PUT      = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } state_t;

    localparam logic [pal_pkg::CNT_W-1:0] CAP_CNT = pal_pkg::CNT_W'(pal_pkg::CAPACITY);
    localparam logic [pal_pkg::CNT_W-1:0] ONE_CNT = pal_pkg::CNT_W'(1);
    localparam logic [pal_pkg::PW-1:0]    ONE_PW  = pal_pkg::PW'(1);

    state_t                       state_reg, state_next;
    logic [pal_pkg::OP_W-1:0]     op_reg, op_next;
    logic [pal_pkg::PW-1:0]       pos_reg, pos_next;
    logic [pal_pkg::VAL_W-1:0]    val_reg, val_next;
    logic [pal_pkg::CNT_W-1:0]    idx_reg, idx_next;
    logic [pal_pkg::CNT_W-1:0]    cnt_reg, cnt_next;
    logic                         status_reg, status_next;
    logic                         found_reg, found_next;
    logic [pal_pkg::VAL_W-1:0]    rdv_reg, rdv_next;

    logic [pal_pkg::PW-1:0]       pos_ext;
    logic [pal_pkg::PW-1:0]       pos_m1;
    logic [pal_pkg::PW-1:0]       cnt_ext;
    logic [pal_pkg::CNT_W-1:0]    idx_m1;

    assign pos_ext = pal_pkg::PW'(in_pos);
    assign pos_m1  = pos_ext - ONE_PW;
    assign cnt_ext = pal_pkg::PW'(cnt_reg);
    assign idx_m1  = idx_reg - ONE_CNT;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        found_next  = found_reg;
        rdv_next    = rdv_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = idx_reg[pal_pkg::ADDR_W-1:0];
        ram_wdata   = val_reg;
        ram_raddr   = idx_m1[pal_pkg::ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next     = in_op;
                    pos_next    = pos_ext;
                    val_next    = in_val;
                    status_next = 1'b0;
                    found_next  = 1'b0;
                    rdv_next    = '0;
                    case (in_op)
                        pal_pkg::OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = ST_DONE;
                        end
                        pal_pkg::OP_INSERT:
                        begin
                            if (cnt_reg >= CAP_CNT || pos_ext == '0 ||
                                pos_ext > cnt_ext + ONE_PW)
                            begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                idx_next   = cnt_reg;
                                state_next = ST_SH_RD;
                            end
                        end
                        pal_pkg::OP_READ:
                        begin
                            if (pos_ext == '0 || pos_ext > cnt_ext)
                            begin
                                status_next = 1'b1;
                                state_next  = ST_DONE;
                            end
                            else
                            begin
                                ram_raddr  = pos_m1[pal_pkg::ADDR_W-1:0];
                                state_next = ST_RD_WAIT;
                            end
                        end
                        pal_pkg::OP_SEARCH,
                        pal_pkg::OP_APPEND:
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN_RD;
                        end
                        default:
                        begin
                            status_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                    endcase
                end
            end
            ST_RD_WAIT:
            begin
                rdv_next   = ram_rdata;
                state_next = ST_DONE;
            end
            ST_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (op_reg == pal_pkg::OP_APPEND)
                    begin
                        if (cnt_reg >= CAP_CNT)
                        begin
                            status_next = 1'b1;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_PUT;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    ram_raddr  = idx_reg[pal_pkg::ADDR_W-1:0];
                    state_next = ST_SCAN_CMP;
                end
            end
            ST_SCAN_CMP:
            begin
                if (ram_rdata == val_reg)
                begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    idx_next   = idx_reg + ONE_CNT;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_SH_RD:
            begin
                // shift loop ends with idx at pos-1, the slot for the new value
                if (pal_pkg::PW'(idx_reg) >= pos_reg)
                begin
                    state_next = ST_SH_WR;
                end
                else
                begin
                    state_next = ST_PUT;
                end
            end
            ST_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_m1;
                state_next = ST_SH_RD;
            end
            ST_PUT:
            begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg + ONE_CNT;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        rdv_reg    <= rdv_next;
    end

    assign res_data.count      = pal_pkg::COUNT_W'(cnt_reg);
    assign res_data.read_value = rdv_reg;
    assign res_data.found      = found_reg;
    assign res_data.status     = status_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PUT |-> cnt_reg < CAP_CNT)
        else $error("write of new entry into a full list");

    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SH_WR |-> idx_reg != '0 && pal_pkg::PW'(idx_reg) >= pos_reg)
        else $error("shift step outside the list");

    a_rd_wait: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_RD_WAIT |-> $past(state_reg) == ST_IDLE)
        else $error("read data wait not entered from idle");

    a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SH_WR || state_reg == ST_PUT))
        else $error("store written outside a shift or put step");
`endif

endmodule

// File: rtl/positional_array_list.sv
`timescale 1ns / 1ps
// channel  dir  handshake          tdata fields (low bit up)
// s_*      in   s_tvalid/s_tready  operation[2:0] position[8:3] item_value[40:9]
// m_*      out  m_tvalid/m_tready  status[0] found[1] read_value[33:2] count[39:34]
//
// One transaction at a time through a store with one read and one write port and
// one compare unit. Clear, bad position, bad opcode: straight to the result. Read:
// one store read. Search/append: read and compare each entry in turn until a hit or
// the end of the list (for append on a miss, plus the write of the item if there is room).
// Insert: shift each entry up by one slot (count - position + 1 entries), then write.
// Reset clears the count and control only; store contents stay undefined.
// A result waits in the output register; a new transaction is taken meanwhile.

module positional_array_list (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pal_pkg::IN_W-1:0]   s_tdata,  // operation, position, item_value, pad
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pal_pkg::OUT_W-1:0]  m_tdata   // status, found, read_value, count
);

    logic                        res_valid;
    logic                        res_ready;
    pal_pkg::result_t            res_data;
    pal_pkg::result_t            out_data;
    logic                        ram_we;
    logic [pal_pkg::ADDR_W-1:0]  ram_waddr;
    logic [pal_pkg::VAL_W-1:0]   ram_wdata;
    logic [pal_pkg::ADDR_W-1:0]  ram_raddr;
    logic [pal_pkg::VAL_W-1:0]   ram_rdata;

    pal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[pal_pkg::OP_W-1:0]),
        .in_pos    (s_tdata[pal_pkg::OP_W+pal_pkg::POS_W-1:pal_pkg::OP_W]),
        .in_val    (s_tdata[pal_pkg::IN_BITS-1:pal_pkg::OP_W+pal_pkg::POS_W]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    pal_ram #(
        .WIDTH (pal_pkg::VAL_W),
        .DEPTH (pal_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pal_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = pal_pkg::OUT_W'(out_data);

endmodule
